// ===== rtl/indexed_max_heap_macros.svh =====
// Assertion macros used by the indexed max-heap datapath.
// Each macro expects signals named aclk and aresetn in the scope where it is used.
`ifndef INDEXED_MAX_HEAP_MACROS_SVH
`define INDEXED_MAX_HEAP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IMH_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("indexed max heap: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define IMH_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("indexed max heap: next-cycle check failed");

`endif

// ===== rtl/imh_pkg.sv =====
// Shared types, sizes and codes for the indexed max-heap.
// This package has no dependencies.
package imh_pkg;

    localparam int HEAP_DEPTH = 1024;
    localparam int ID_BITS    = 16;
    localparam int KEY_BITS   = 20;
    localparam int POS_W      = $clog2(HEAP_DEPTH);
    localparam int CNT_W      = POS_W + 1;
    localparam int CHILD_W    = POS_W + 2;
    localparam int ID_SPACE   = 2 ** ID_BITS;
    localparam int TOTAL_W    = 11;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 32;

    typedef logic [KEY_BITS-1:0] key_t;
    typedef logic [ID_BITS-1:0]  id_t;
    typedef logic [POS_W-1:0]    pos_t;
    typedef logic [CNT_W-1:0]    cnt_t;
    typedef logic [CHILD_W-1:0]  child_t;

    typedef struct packed {
        key_t key;
        id_t  id;
    } slot_t;

    typedef enum logic [1:0] {
        REQ_INSERT  = 2'd0,
        REQ_EXTRACT = 2'd1,
        REQ_RAISE   = 2'd2,
        REQ_LOWER   = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        DP_NONE,
        DP_LATCH,
        DP_LD_INS,
        DP_RD_EXT,
        DP_LD_EXT,
        DP_RD_MAP,
        DP_RD_POS,
        DP_LD_ADJ,
        DP_RD_UP,
        DP_STEP_UP,
        DP_RD_DOWN,
        DP_STEP_DOWN,
        DP_FINISH
    } dp_op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_EXT_WAIT,
        S_MAP_WAIT,
        S_POS_WAIT,
        S_UP_RD,
        S_UP_CHK,
        S_DN_RD,
        S_DN_CHK,
        S_RESP
    } state_t;

    typedef struct packed {
        dp_op_t  op;
        logic    out_load;
        status_t out_status;
    } cmd_t;

    typedef struct packed {
        req_t req;
        logic full;
        logic empty;
        logic pos_live;
        logic hole_zero;
        logic up_go;
        logic dn_go;
        logic out_free;
    } stat_t;

endpackage

// ===== rtl/indexed_max_heap.sv =====
// Indexed binary max-heap of up to 1024 (key, id) entries with an id-to-slot position map.
// One request at a time: s_tready is high only while idle. Each level of a sift is one registered
// read of the slot memory and one compare-and-write step; the slowest request is a lower from the
// root to a leaf, and its result may then wait for the receiver. Reset (aresetn low) empties the heap.
module indexed_max_heap import imh_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Request channel.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // s_tdata: item_id [15:0], key_value [35:16], zeros [39:36].
    input  logic [S_TDATA_W-1:0] s_tdata,
    // s_tuser: req_type [1:0] (insert, extract max, raise key, lower key).
    input  logic [1:0]           s_tuser,
    // Result channel.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // m_tdata: result_id [15:0], entry_total [26:16], zeros [31:27].
    output logic [M_TDATA_W-1:0] m_tdata,
    // m_tuser: status [1:0] (ok, heap empty on extract, heap full on insert).
    output logic [1:0]           m_tuser
);

    // The controller steps through each request: it dispatches on the request type,
    // then drives the sift as pairs of read and compare-and-write steps. The datapath
    // keeps the entry being moved in a register and shifts each displaced entry into
    // the hole, updating the position map as it goes; the moving entry is written once
    // at its final slot. One result item is produced per request, held in an output
    // register until the downstream side takes it.
    cmd_t  cmd;
    stat_t stat;

    imh_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    imh_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== rtl/imh_datapath.sv =====
// Datapath of the indexed max-heap: slot memory, position map, sift registers, output register.
// Depends on imh_pkg and indexed_max_heap_macros.svh.
`include "indexed_max_heap_macros.svh"

module imh_datapath import imh_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [1:0]           s_tuser,
    input  cmd_t                 cmd,
    output stat_t                stat,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [1:0]           m_tuser
);

    slot_t slot_mem [HEAP_DEPTH];
    pos_t  map_mem  [ID_SPACE];

    req_t    req_type_reg, req_type_next;
    id_t     req_id_reg, req_id_next;
    key_t    req_key_reg, req_key_next;
    slot_t   mov_reg, mov_next;
    pos_t    hole_reg, hole_next;
    cnt_t    cnt_reg, cnt_next;
    logic    moved_reg, moved_next;
    id_t     result_reg, result_next;
    slot_t   rd_a_reg, rd_b_reg;
    pos_t    map_rd_reg;
    logic    m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    status_t m_tuser_reg, m_tuser_next;

    logic   rd_en, map_ren, slot_we, map_we;
    pos_t   rd_a_addr, rd_b_addr, slot_waddr, map_wdata;
    id_t    map_raddr, map_waddr;
    slot_t  slot_wdata;
    cnt_t   cnt_dec;
    child_t left, right;
    pos_t   parent, dn_pos;
    slot_t  dn_child;
    logic   l_ok, r_ok, dn_go, up_go, out_free;

    assign cnt_dec = cnt_reg - cnt_t'(1);
    assign left    = child_t'({hole_reg, 1'b1});
    assign right   = left + child_t'(1);
    assign parent  = pos_t'((hole_reg - pos_t'(1)) >> 1);

    // Child selection: strict compares, left child wins a tie.
    assign l_ok = (left < {1'b0, cnt_reg}) && (rd_a_reg.key > mov_reg.key);
    assign r_ok = (right < {1'b0, cnt_reg})
                  && (rd_b_reg.key > (l_ok ? rd_a_reg.key : mov_reg.key));
    assign dn_go    = l_ok || r_ok;
    assign dn_child = r_ok ? rd_b_reg : rd_a_reg;
    assign dn_pos   = r_ok ? right[POS_W-1:0] : left[POS_W-1:0];
    assign up_go    = (hole_reg != '0) && (rd_a_reg.key < mov_reg.key);
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        stat.req       = req_type_reg;
        stat.full      = (cnt_reg == cnt_t'(HEAP_DEPTH));
        stat.empty     = (cnt_reg == '0);
        stat.pos_live  = ({1'b0, map_rd_reg} < cnt_reg);
        stat.hole_zero = (hole_reg == '0);
        stat.up_go     = up_go;
        stat.dn_go     = dn_go;
        stat.out_free  = out_free;
    end

    always_comb begin
        rd_en      = 1'b0;
        rd_a_addr  = '0;
        rd_b_addr  = '0;
        map_ren    = 1'b0;
        map_raddr  = req_id_reg;
        slot_we    = 1'b0;
        slot_waddr = hole_reg;
        slot_wdata = mov_reg;
        map_we     = 1'b0;
        map_waddr  = mov_reg.id;
        map_wdata  = hole_reg;

        req_type_next = req_type_reg;
        req_id_next   = req_id_reg;
        req_key_next  = req_key_reg;
        mov_next      = mov_reg;
        hole_next     = hole_reg;
        cnt_next      = cnt_reg;
        moved_next    = moved_reg;
        result_next   = result_reg;

        unique case (cmd.op)
            DP_LATCH: begin
                req_type_next = req_t'(s_tuser);
                req_id_next   = s_tdata[ID_BITS-1:0];
                req_key_next  = s_tdata[ID_BITS +: KEY_BITS];
                result_next   = '0;
            end
            DP_LD_INS: begin
                mov_next   = '{key: req_key_reg, id: req_id_reg};
                hole_next  = cnt_reg[POS_W-1:0];
                moved_next = 1'b1;
            end
            DP_RD_EXT: begin
                rd_en     = 1'b1;
                rd_a_addr = '0;
                rd_b_addr = cnt_dec[POS_W-1:0];
            end
            DP_LD_EXT: begin
                // The removed id keeps the old last slot in the map.
                map_we      = 1'b1;
                map_waddr   = rd_a_reg.id;
                map_wdata   = cnt_dec[POS_W-1:0];
                result_next = rd_a_reg.id;
                mov_next    = rd_b_reg;
                hole_next   = '0;
                moved_next  = 1'b1;
                cnt_next    = cnt_dec;
            end
            DP_RD_MAP: begin
                map_ren = 1'b1;
            end
            DP_RD_POS: begin
                rd_en     = 1'b1;
                rd_a_addr = map_rd_reg;
                hole_next = map_rd_reg;
            end
            DP_LD_ADJ: begin
                mov_next   = '{key: req_key_reg, id: rd_a_reg.id};
                moved_next = 1'b0;
            end
            DP_RD_UP: begin
                rd_en     = 1'b1;
                rd_a_addr = parent;
            end
            DP_STEP_UP: begin
                slot_we    = 1'b1;
                slot_wdata = rd_a_reg;
                map_we     = 1'b1;
                map_waddr  = rd_a_reg.id;
                hole_next  = parent;
                moved_next = 1'b1;
            end
            DP_RD_DOWN: begin
                rd_en     = 1'b1;
                rd_a_addr = left[POS_W-1:0];
                rd_b_addr = right[POS_W-1:0];
            end
            DP_STEP_DOWN: begin
                slot_we    = 1'b1;
                slot_wdata = dn_child;
                map_we     = 1'b1;
                map_waddr  = dn_child.id;
                hole_next  = dn_pos;
                moved_next = 1'b1;
            end
            DP_FINISH: begin
                // The moving entry lands in the hole; its map entry changes only if it moved.
                slot_we = 1'b1;
                map_we  = moved_reg;
                if (req_type_reg == REQ_INSERT) begin
                    cnt_next = cnt_reg + cnt_t'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {{(M_TDATA_W - TOTAL_W - ID_BITS){1'b0}},
                             TOTAL_W'(cnt_reg), result_reg};
            m_tuser_next  = cmd.out_status;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_type_reg <= req_type_next;
        req_id_reg   <= req_id_next;
        req_key_reg  <= req_key_next;
        mov_reg      <= mov_next;
        hole_reg     <= hole_next;
        moved_reg    <= moved_next;
        result_reg   <= result_next;
        m_tdata_reg  <= m_tdata_next;
        m_tuser_reg  <= m_tuser_next;
    end

    always_ff @(posedge aclk) begin
        if (slot_we) begin
            slot_mem[slot_waddr] <= slot_wdata;
        end
        if (rd_en) begin
            rd_a_reg <= slot_mem[rd_a_addr];
            rd_b_reg <= slot_mem[rd_b_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (map_we) begin
            map_mem[map_waddr] <= map_wdata;
        end
        if (map_ren) begin
            map_rd_reg <= map_mem[map_raddr];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `IMH_ASSERT_IMPLY(a_cnt_bound, 1'b1, cnt_reg <= cnt_t'(HEAP_DEPTH))
    `IMH_ASSERT_IMPLY(a_step_down_go, cmd.op == DP_STEP_DOWN, dn_go)
    `IMH_ASSERT_IMPLY(a_step_up_not_root, cmd.op == DP_STEP_UP, hole_reg != '0)
    `IMH_ASSERT_IMPLY(a_load_when_free, cmd.out_load, out_free)
    `IMH_ASSERT_NEXT(a_load_shows, cmd.out_load, m_tvalid_reg)

endmodule

// ===== rtl/imh_ctrl.sv =====
// Controller of the indexed max-heap: sequences requests and sift steps through the datapath.
// Depends on imh_pkg.
module imh_ctrl import imh_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_tvalid,
    output logic  s_tready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t  state_reg, state_next;
    status_t resp_reg, resp_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            resp_reg  <= ST_OK;
        end else begin
            state_reg <= state_next;
            resp_reg  <= resp_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        resp_next      = resp_reg;
        cmd.op         = DP_NONE;
        cmd.out_load   = 1'b0;
        cmd.out_status = resp_reg;
        s_tready       = (state_reg == S_IDLE);

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.op     = DP_LATCH;
                    resp_next  = ST_OK;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (stat.req)
                    REQ_INSERT: begin
                        if (stat.full) begin
                            resp_next  = ST_FULL;
                            state_next = S_RESP;
                        end else begin
                            cmd.op     = DP_LD_INS;
                            state_next = S_UP_RD;
                        end
                    end
                    REQ_EXTRACT: begin
                        if (stat.empty) begin
                            resp_next  = ST_EMPTY;
                            state_next = S_RESP;
                        end else begin
                            cmd.op     = DP_RD_EXT;
                            state_next = S_EXT_WAIT;
                        end
                    end
                    REQ_RAISE, REQ_LOWER: begin
                        cmd.op     = DP_RD_MAP;
                        state_next = S_MAP_WAIT;
                    end
                    default: begin
                        state_next = S_RESP;
                    end
                endcase
            end
            S_EXT_WAIT: begin
                cmd.op     = DP_LD_EXT;
                state_next = S_DN_RD;
            end
            S_MAP_WAIT: begin
                if (stat.pos_live) begin
                    cmd.op     = DP_RD_POS;
                    state_next = S_POS_WAIT;
                end else begin
                    state_next = S_RESP;
                end
            end
            S_POS_WAIT: begin
                cmd.op     = DP_LD_ADJ;
                state_next = (stat.req == REQ_RAISE) ? S_UP_RD : S_DN_RD;
            end
            S_UP_RD: begin
                if (stat.hole_zero) begin
                    cmd.op     = DP_FINISH;
                    state_next = S_RESP;
                end else begin
                    cmd.op     = DP_RD_UP;
                    state_next = S_UP_CHK;
                end
            end
            S_UP_CHK: begin
                if (stat.up_go) begin
                    cmd.op     = DP_STEP_UP;
                    state_next = S_UP_RD;
                end else begin
                    cmd.op     = DP_FINISH;
                    state_next = S_RESP;
                end
            end
            S_DN_RD: begin
                cmd.op     = DP_RD_DOWN;
                state_next = S_DN_CHK;
            end
            S_DN_CHK: begin
                if (stat.dn_go) begin
                    cmd.op     = DP_STEP_DOWN;
                    state_next = S_DN_RD;
                end else begin
                    cmd.op     = DP_FINISH;
                    state_next = S_RESP;
                end
            end
            S_RESP: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== test/imh_checker.sv =====
// Scoreboard for the indexed max-heap: watches both channels, keeps its own heap
// image, predicts each result and compares it. Depends on imh_pkg.
`timescale 1ns / 100ps
module imh_checker import imh_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [1:0]           s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic [1:0]           m_tuser,
    output int                   fail_count,
    output int                   pending
);
    typedef struct packed {
        id_t     rid;
        status_t st;
        logic [TOTAL_W-1:0] total;
    } heap_reply_t;

    key_t        hkey [HEAP_DEPTH];
    id_t         hid  [HEAP_DEPTH];
    int unsigned slot_of [ID_SPACE];
    int unsigned held;
    heap_reply_t replies [$];

    assign pending = replies.size();

    function automatic void swap_entries(int unsigned a, int unsigned b);
        key_t k;
        id_t  d;
        k = hkey[a];
        d = hid[a];
        slot_of[d] = b;
        slot_of[hid[b]] = a;
        hkey[a] = hkey[b];
        hid[a]  = hid[b];
        hkey[b] = k;
        hid[b]  = d;
    endfunction

    function automatic void climb(int unsigned p);
        while (p > 0 && hkey[(p - 1) / 2] < hkey[p]) begin
            swap_entries((p - 1) / 2, p);
            p = (p - 1) / 2;
        end
    endfunction

    function automatic void descend(int unsigned p);
        int unsigned best;
        while (p < held) begin
            best = p;
            if (2 * p + 1 < held && hkey[2 * p + 1] > hkey[p]) best = 2 * p + 1;
            if (2 * p + 2 < held && hkey[2 * p + 2] > hkey[best]) best = 2 * p + 2;
            if (best == p) break;
            swap_entries(best, p);
            p = best;
        end
    endfunction

    function automatic heap_reply_t apply_request(req_t rq, id_t id, key_t key);
        heap_reply_t r;
        int unsigned p;
        r = '{rid: '0, st: ST_OK, total: '0};
        case (rq)
            REQ_INSERT: begin
                if (held < HEAP_DEPTH) begin
                    hkey[held] = key;
                    hid[held]  = id;
                    slot_of[id] = held;
                    climb(held);
                    held++;
                end else begin
                    r.st = ST_FULL;
                end
            end
            REQ_EXTRACT: begin
                if (held == 0) begin
                    r.st = ST_EMPTY;
                end else begin
                    r.rid = hid[0];
                    swap_entries(0, held - 1);
                    held--;
                    descend(0);
                end
            end
            default: begin
                p = slot_of[id];
                if (p < held) begin
                    hkey[p] = key;
                    if (rq == REQ_RAISE) climb(p);
                    else descend(p);
                end
            end
        endcase
        r.total = held[TOTAL_W-1:0];
        return r;
    endfunction

    always @(posedge aclk) begin
        heap_reply_t exp_r;
        if (!aresetn) begin
            held = 0;
            replies.delete();
            fail_count <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (replies.size() == 0) begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10)
                        $display("unexpected result: tdata=%h tuser=%0d", m_tdata, m_tuser);
                end else begin
                    exp_r = replies.pop_front();
                    if (m_tdata[15:0] !== exp_r.rid || m_tuser !== exp_r.st
                        || m_tdata[26:16] !== exp_r.total || m_tdata[31:27] !== '0) begin
                        fail_count <= fail_count + 1;
                        if (fail_count < 10)
                            $display("mismatch: id %h/%h status %0d/%0d total %0d/%0d",
                                     exp_r.rid, m_tdata[15:0], exp_r.st, m_tuser,
                                     exp_r.total, m_tdata[26:16]);
                    end
                end
            end
            if (s_tvalid && s_tready)
                replies.push_back(apply_request(req_t'(s_tuser), s_tdata[15:0],
                                                s_tdata[35:16]));
        end
    end
endmodule

// ===== test/tb_indexed_max_heap.sv =====
// Top of the indexed max-heap testbench: clock, reset, request stimulus with
// random idling, result back-pressure and the verdict. Depends on imh_pkg, imh_checker, indexed_max_heap.
`timescale 1ns / 100ps
module tb_indexed_max_heap;
    import imh_pkg::*;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [1:0]           s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [1:0]           m_tuser;
    int                   fail_count;
    int                   pending;

    // Idle percentages of the sender and receiver for the current phase.
    int unsigned send_idle = 28;
    int unsigned recv_idle = 86;
    int unsigned quiet = 0;
    logic        timed_out = 1'b0;

    // Ids whose inserts were taken; raise and lower only use these, because a
    // map entry that was never written must never be read. The entry count is
    // followed here so that an insert refused on a full heap adds no id.
    id_t         known_ids [$];
    int unsigned heap_fill = 0;

    always #4 aclk = ~aclk;

    indexed_max_heap dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    imh_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .fail_count(fail_count), .pending(pending)
    );

    // The receiver stalls at random with the current phase's percentage.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle);
    end

    // Watchdog: a long stretch without any accepted item means a hang.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
            if (quiet > 20000) timed_out <= 1'b1;
        end
    end

    always @(posedge timed_out) begin
        $display("indexed_max_heap test failed");
        $finish;
    end

    // Sends one item and holds it until accepted. Random idle cycles are
    // inserted before it according to the sender's percentage.
    task automatic send_request(req_t rq, id_t id, key_t key);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= rq;
        s_tdata  <= {4'b0, key, id};
        if (rq == REQ_INSERT && heap_fill < HEAP_DEPTH) begin
            known_ids.push_back(id);
            heap_fill++;
        end else if (rq == REQ_EXTRACT && heap_fill != 0) begin
            heap_fill--;
        end
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    function automatic id_t pick_known();
        if (known_ids.size() == 0) return '0;
        return known_ids[$urandom_range(known_ids.size() - 1)];
    endfunction

    // A random request biased so that the heap both grows and shrinks. The id
    // range is narrowed often so that duplicates and stale map entries happen.
    task automatic random_request(int unsigned grow);
        int unsigned pick;
        id_t  id;
        key_t key;
        pick = $urandom_range(99);
        id   = ($urandom_range(1)) ? id_t'($urandom_range(31)) : id_t'($urandom);
        key  = ($urandom_range(3) == 0) ? key_t'($urandom_range(7)) : key_t'($urandom);
        if (pick < grow)
            send_request(REQ_INSERT, id, key);
        else if (pick < grow + 30 || known_ids.size() == 0)
            send_request(REQ_EXTRACT, '0, '0);
        else
            send_request((pick & 1) ? REQ_RAISE : REQ_LOWER, pick_known(), key);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part: empty extract, field extremes, ties, duplicates,
        // stale ids, wrong-way raise and lower.
        send_request(REQ_EXTRACT, '0, '0);
        send_request(REQ_INSERT, 16'hFFFF, 20'hFFFFF);
        send_request(REQ_INSERT, 16'h0000, 20'h00000);
        send_request(REQ_INSERT, 16'h0005, 20'h00100);
        send_request(REQ_INSERT, 16'h0006, 20'h00100);
        send_request(REQ_INSERT, 16'h0005, 20'h00200);
        send_request(REQ_RAISE, 16'h0000, 20'hFFFFF);
        send_request(REQ_LOWER, 16'hFFFF, 20'h00000);
        send_request(REQ_RAISE, 16'h0006, 20'h00001);
        send_request(REQ_LOWER, 16'h0005, 20'hFFFFE);
        send_request(REQ_EXTRACT, 16'hFFFF, 20'hFFFFF);
        send_request(REQ_EXTRACT, '0, '0);
        send_request(REQ_RAISE, 16'h0000, 20'h00050);
        send_request(REQ_EXTRACT, '0, '0);
        send_request(REQ_EXTRACT, '0, '0);
        send_request(REQ_EXTRACT, '0, '0);
        send_request(REQ_EXTRACT, '0, '0);
        send_request(REQ_LOWER, 16'hFFFF, 20'h00003);
        send_request(REQ_EXTRACT, '0, '0);

        // Fill to capacity and try one more insert to see the full flag.
        repeat (HEAP_DEPTH + 1) send_request(REQ_INSERT, id_t'($urandom), key_t'($urandom));
        repeat (100) random_request(5);
        repeat (300) random_request(45);
        drain();
        send_idle = 86; recv_idle = 28;
        repeat (250) random_request(40);
        drain();
        send_idle = 0; recv_idle = 0;
        repeat (300) random_request(50);
        drain();

        if (fail_count == 0)
            $display("indexed_max_heap test passed");
        else
            $display("indexed_max_heap test failed");
        $finish;
    end
endmodule
